// ----- hdl/lcdws_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types and constants shared by the character LCD write sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdws_pkg;

    // request kinds, coded as the func input
    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // sub-phase of one byte write on the bus
    typedef enum logic [1:0] {
        SUB_SETUP   = 2'd0,
        SUB_STROBE  = 2'd1,
        SUB_RELEASE = 2'd2
    } sub_t;

    // configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_LINE_LENGTH = 3'd0,
        REG_PULSE_US    = 3'd1,
        REG_SETTLE_US   = 3'd2,
        REG_CLEAR_US    = 3'd3,
        REG_POWER_UP_US = 3'd4
    } reg_idx_t;

    localparam int unsigned POS_W  = 6;
    localparam int unsigned HOLD_W = 16;

    localparam logic [POS_W-1:0]  POS_MAX = 6'd63;

    localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0E;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;

    // reset values of the configuration registers
    localparam logic [5:0]  RST_LINE_LENGTH = 6'd16;
    localparam logic [7:0]  RST_PULSE_US    = 8'd1;
    localparam logic [9:0]  RST_SETTLE_US   = 10'd40;
    localparam logic [15:0] RST_CLEAR_US    = 16'd2000;
    localparam logic [15:0] RST_POWER_UP_US = 16'd20000;

    // one request as queued between front and back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       jump;
    } item_t;

    // timing registers seen by the back end
    typedef struct packed {
        logic [7:0]  pulse_us;
        logic [9:0]  settle_us;
        logic [15:0] clear_us;
        logic [15:0] power_up_us;
    } timing_t;

    // command byte of each init write
    function automatic logic [7:0] init_cmd(input logic [1:0] widx);
        logic [7:0] cmd;
        case (widx)
            2'd0:    cmd = CMD_FUNC_SET;
            2'd1:    cmd = CMD_ENTRY;
            2'd2:    cmd = CMD_DISP_ON;
            default: cmd = CMD_CLEAR;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lcdws_front.sv -----
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, tracks the string character position and decides
// whether a second-line jump goes ahead of a character.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire logic [1:0]             func,
    input  wire logic [7:0]             value,
    input  wire logic                   string_start,
    input  wire logic [5:0]             line_length,
    input  wire logic                   q_full,
    output logic                        q_wr,
    output lcdws_pkg::item_t            q_item
);

    logic [lcdws_pkg::POS_W-1:0] pos_reg;
    logic [lcdws_pkg::POS_W-1:0] pos_next;
    logic [lcdws_pkg::POS_W-1:0] pos_eff;
    logic                        accept;
    lcdws_pkg::kind_t            kind;

    assign accept = push && !q_full;
    assign kind   = lcdws_pkg::kind_t'(func);

    // position as seen by this character
    assign pos_eff = string_start ? '0 : pos_reg;

    // classify the request
    always_comb
    begin
        q_wr        = accept;
        q_item.kind = kind;
        q_item.data = value;
        q_item.jump = (kind == lcdws_pkg::KIND_CHAR) && (pos_eff == line_length)
                      && (pos_eff != lcdws_pkg::POS_MAX);
    end

    // saturating character counter
    always_comb
    begin
        pos_next = pos_reg;
        if (accept && (kind == lcdws_pkg::KIND_CHAR))
        begin
            if (pos_eff != lcdws_pkg::POS_MAX)
                pos_next = pos_eff + 1'b1;
            else
                pos_next = pos_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

// ----- hdl/lcdws_queue.sv -----
// ----------------------------------------------------------------------------
// lcdws_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire lcdws_pkg::item_t wr_item,
    output logic                  full,
    input  wire logic             rd,
    output lcdws_pkg::item_t      rd_item,
    output logic                  empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcdws_pkg::item_t mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_item = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // fill count stays within depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue count above depth");

    // pointers agree with the fill count when empty
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

// ----- hdl/lcdws_back.sv -----
// ----------------------------------------------------------------------------
// lcdws_back
// Expands the queue head request into bus phases for the result register,
// one phase per cycle while a request waits and the output is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lcdws_pkg::timing_t           timing,
    input  wire lcdws_pkg::item_t             head,
    input  wire logic                         q_empty,
    output logic                              q_rd,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              reg_select,
    output logic                              enable,
    output logic [7:0]                        bus_byte,
    output logic [lcdws_pkg::HOLD_W-1:0]      hold_us,
    output logic                              last
);

    logic                 fresh_reg;
    logic                 fresh_next;
    logic [1:0]           widx_reg;
    logic [1:0]           widx_next;
    lcdws_pkg::sub_t      sub_reg;
    lcdws_pkg::sub_t      sub_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 pwr;
    logic [1:0]           eff_widx;
    lcdws_pkg::sub_t      eff_sub;
    logic [1:0]           last_widx;
    logic                 is_last;
    logic                 load;
    logic [15:0]          extra;
    logic [16:0]          rel_sum;
    logic                 ph_rs;
    logic                 ph_en;
    logic [7:0]           ph_byte;
    logic [15:0]          ph_hold;

    // position inside the head request
    always_comb
    begin
        pwr = fresh_reg && (head.kind == lcdws_pkg::KIND_INIT);
        if (fresh_reg)
        begin
            eff_widx = ((head.kind == lcdws_pkg::KIND_CHAR) && !head.jump) ? 2'd1 : 2'd0;
            eff_sub  = lcdws_pkg::SUB_SETUP;
        end
        else
        begin
            eff_widx = widx_reg;
            eff_sub  = sub_reg;
        end
        case (head.kind)
            lcdws_pkg::KIND_INIT: last_widx = 2'd3;
            lcdws_pkg::KIND_CHAR: last_widx = 2'd1;
            default:              last_widx = 2'd0;
        endcase
        is_last = !pwr && (eff_sub == lcdws_pkg::SUB_RELEASE) && (eff_widx == last_widx);
    end

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_rd  = load && is_last;
    assign empty = !out_valid_reg;

    // byte, select and extra wait of the current write
    always_comb
    begin
        ph_rs = 1'b0;
        extra = '0;
        case (head.kind)
            lcdws_pkg::KIND_INIT:
            begin
                ph_byte = lcdws_pkg::init_cmd(eff_widx);
                extra   = (eff_widx == 2'd3) ? timing.clear_us : {6'd0, timing.settle_us};
            end
            lcdws_pkg::KIND_CMD:
            begin
                ph_byte = head.data;
            end
            lcdws_pkg::KIND_CHAR:
            begin
                ph_byte = (eff_widx == 2'd0) ? lcdws_pkg::CMD_LINE_TWO : head.data;
                ph_rs   = (eff_widx != 2'd0);
            end
            default:
            begin
                ph_byte = lcdws_pkg::CMD_CLEAR;
                extra   = timing.clear_us;
            end
        endcase
    end

    // hold time and strobe level of the phase
    assign rel_sum = {7'd0, timing.settle_us} + {1'b0, extra};

    always_comb
    begin
        ph_en = 1'b0;
        case (eff_sub)
            lcdws_pkg::SUB_SETUP:   ph_hold = '0;
            lcdws_pkg::SUB_STROBE:
            begin
                ph_hold = {8'd0, timing.pulse_us};
                ph_en   = 1'b1;
            end
            default:                ph_hold = rel_sum[16] ? 16'hFFFF : rel_sum[15:0];
        endcase
    end

    // step through the phases
    always_comb
    begin
        fresh_next     = fresh_reg;
        widx_next      = widx_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            fresh_next     = 1'b0;
            if (pwr)
            begin
                widx_next = 2'd0;
                sub_next  = lcdws_pkg::SUB_SETUP;
            end
            else if (is_last)
            begin
                fresh_next = 1'b1;
                widx_next  = 2'd0;
                sub_next   = lcdws_pkg::SUB_SETUP;
            end
            else
            begin
                case (eff_sub)
                    lcdws_pkg::SUB_SETUP:
                    begin
                        widx_next = eff_widx;
                        sub_next  = lcdws_pkg::SUB_STROBE;
                    end
                    lcdws_pkg::SUB_STROBE:
                    begin
                        widx_next = eff_widx;
                        sub_next  = lcdws_pkg::SUB_RELEASE;
                    end
                    default:
                    begin
                        widx_next = eff_widx + 1'b1;
                        sub_next  = lcdws_pkg::SUB_SETUP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            widx_reg      <= '0;
            sub_reg       <= lcdws_pkg::SUB_SETUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            widx_reg      <= widx_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reg_select <= pwr ? 1'b0 : ph_rs;
            enable     <= pwr ? 1'b0 : ph_en;
            bus_byte   <= pwr ? 8'd0 : ph_byte;
            hold_us    <= pwr ? timing.power_up_us : ph_hold;
            last       <= is_last;
        end
    end

    // between requests the write position is at its start
    a_fresh_sub: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> (sub_reg == lcdws_pkg::SUB_SETUP) && (widx_reg == 2'd0))
        else $error("sub-phase left over between requests");

    // the final phase of a request frees the queue head
    a_last_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> fresh_reg)
        else $error("request not retired after its final phase");

    // command and clear requests never leave the first write
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!fresh_reg && !q_empty && ((head.kind == lcdws_pkg::KIND_CMD)
            || (head.kind == lcdws_pkg::KIND_CLEAR))) |-> (widx_reg == 2'd0))
        else $error("single write request moved past its write");

    // strobe phases only follow a setup phase of the same request
    a_strobe_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !pwr && (eff_sub == lcdws_pkg::SUB_STROBE)) |-> !fresh_reg)
        else $error("strobe phase at the start of a request");

endmodule

`default_nettype wire

// ----- hdl/char_lcd_parallel_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_parallel_write_sequencer
// Turns LCD requests (init, command, character, clear) into 8-bit bus
// phases with RS, RW, EN, data and hold time.
//
//   port group     direction  handshake            contents
//   request        in         push / full          func, value, string_start
//   bus phase      out        empty / pop          reg_select, read_write, enable,
//                                                  bus_byte, hold_us, last
//   registers      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One bus phase leaves per cycle while requests wait and pop is held high: init
// expands into 13 phases, a command or clear into 3, a character into 3, or 6
// with the second-line jump.
// The front takes one request per cycle while the request queue has room.
// Reset clears the character position and the queue, marks the result register
// empty without clearing its contents, and loads the register defaults.
// A pop held low stalls the phase generator; the front keeps filling the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_parallel_write_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request side
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   func,
    input  wire logic [7:0]   value,
    input  wire logic         string_start,
    // phase side
    output logic              empty,
    input  wire logic         pop,
    output logic              reg_select,
    output logic              read_write,
    output logic              enable,
    output logic [7:0]        bus_byte,
    output logic [15:0]       hold_us,
    output logic              last,
    // register port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [5:0]          line_length_reg;
    logic [7:0]          pulse_us_reg;
    logic [9:0]          settle_us_reg;
    logic [15:0]         clear_us_reg;
    logic [15:0]         power_up_us_reg;
    logic                cfg_wr;
    lcdws_pkg::reg_idx_t cfg_idx;
    lcdws_pkg::timing_t  timing;

    logic                q_wr;
    logic                q_rd;
    logic                q_empty;
    lcdws_pkg::item_t    q_wr_item;
    lcdws_pkg::item_t    q_head;

    assign pready     = 1'b1;
    assign read_write = 1'b0;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_idx    = lcdws_pkg::reg_idx_t'(paddr[4:2]);

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= lcdws_pkg::RST_LINE_LENGTH;
            pulse_us_reg    <= lcdws_pkg::RST_PULSE_US;
            settle_us_reg   <= lcdws_pkg::RST_SETTLE_US;
            clear_us_reg    <= lcdws_pkg::RST_CLEAR_US;
            power_up_us_reg <= lcdws_pkg::RST_POWER_UP_US;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lcdws_pkg::REG_LINE_LENGTH: line_length_reg <= pwdata[5:0];
                lcdws_pkg::REG_PULSE_US:    pulse_us_reg    <= pwdata[7:0];
                lcdws_pkg::REG_SETTLE_US:   settle_us_reg   <= pwdata[9:0];
                lcdws_pkg::REG_CLEAR_US:    clear_us_reg    <= pwdata[15:0];
                lcdws_pkg::REG_POWER_UP_US: power_up_us_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_idx)
            lcdws_pkg::REG_LINE_LENGTH: prdata = {26'd0, line_length_reg};
            lcdws_pkg::REG_PULSE_US:    prdata = {24'd0, pulse_us_reg};
            lcdws_pkg::REG_SETTLE_US:   prdata = {22'd0, settle_us_reg};
            lcdws_pkg::REG_CLEAR_US:    prdata = {16'd0, clear_us_reg};
            lcdws_pkg::REG_POWER_UP_US: prdata = {16'd0, power_up_us_reg};
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        timing.pulse_us    = pulse_us_reg;
        timing.settle_us   = settle_us_reg;
        timing.clear_us    = clear_us_reg;
        timing.power_up_us = power_up_us_reg;
    end

    // request classification
    lcdws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .func         (func),
        .value        (value),
        .string_start (string_start),
        .line_length  (line_length_reg),
        .q_full       (full),
        .q_wr         (q_wr),
        .q_item       (q_wr_item)
    );

    // request queue
    lcdws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_wr_item),
        .full    (full),
        .rd      (q_rd),
        .rd_item (q_head),
        .empty   (q_empty)
    );

    // phase generation
    lcdws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .reg_select (reg_select),
        .enable     (enable),
        .bus_byte   (bus_byte),
        .hold_us    (hold_us),
        .last       (last)
    );

endmodule

`default_nettype wire

// ----- tb/tb_char_lcd_parallel_write_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_parallel_write_sequencer
// Self-checking bench for the LCD write sequencer. Requests are pushed with
// random gaps, bus phases are popped with random stalls, and every phase is
// compared field by field against a scoreboard fed by a behavioral model of
// the phase expansion. A short directed table covers the register extremes,
// every request kind, hold saturation and the line jump. A long random part
// follows, mostly well-formed strings, under changing register settings.
// ----------------------------------------------------------------------------

module tb_char_lcd_parallel_write_sequencer;

    localparam int ITEM_TARGET = 460;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DIR_ROWS    = 26;

    // indexes past the register list, writes there are dropped
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    // one bus phase as seen on the result ports
    typedef struct packed {
        logic        rs;
        logic        rw;
        logic        en;
        logic [7:0]  bus;
        logic [15:0] hold;
        logic        last;
    } phase_t;

    // one row of the directed table: a register write or a request
    typedef struct packed {
        logic             is_reg;
        logic [2:0]       reg_idx;
        logic [31:0]      reg_data;
        lcdws_pkg::kind_t kind;
        logic [7:0]       val;
        logic             start;
        logic             typed;
        logic [3:0]       t_n;
        logic [7:0]       t_bus;
        logic [15:0]      t_hold;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    lcdws_pkg::kind_t req_kind = lcdws_pkg::KIND_INIT;
    logic [7:0]       req_value = 8'h00;
    logic             req_start = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic             reg_select;
    logic             read_write;
    logic             enable;
    logic [7:0]       bus_byte;
    logic [15:0]      hold_us;
    logic             last;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [4:0]       paddr = 5'd0;
    logic [31:0]      pwdata = 32'd0;
    logic [31:0]      prdata;
    logic             pready;

    // hand-typed expectation travelling with a directed request
    logic        row_typed = 1'b0;
    logic [3:0]  row_n = 4'd0;
    logic [7:0]  row_bus = 8'h00;
    logic [15:0] row_hold = 16'h0000;

    // model copy of the registers and the character counter
    logic [5:0]  line_len_cfg = lcdws_pkg::RST_LINE_LENGTH;
    logic [7:0]  pulse_cfg    = lcdws_pkg::RST_PULSE_US;
    logic [9:0]  settle_cfg   = lcdws_pkg::RST_SETTLE_US;
    logic [15:0] clear_cfg    = lcdws_pkg::RST_CLEAR_US;
    logic [15:0] power_cfg    = lcdws_pkg::RST_POWER_UP_US;
    logic [5:0]  char_pos     = '0;

    phase_t   pending_phases[$];
    phase_t   scratch_phases [0:12];
    int       scratch_n;
    int       fail_count = 0;
    int       items_sent = 0;
    bit       tx_idle_on = 1'b1;
    bit       rx_idle_on = 1'b1;
    int       rx_stall = 0;
    int       rx_cycles = 0;
    dir_row_t dir_rows [0:DIR_ROWS-1];

    char_lcd_parallel_write_sequencer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (req_kind),
        .value        (req_value),
        .string_start (req_start),
        .empty        (empty),
        .pop          (pop),
        .reg_select   (reg_select),
        .read_write   (read_write),
        .enable       (enable),
        .bus_byte     (bus_byte),
        .hold_us      (hold_us),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // phase expansion model
    // ------------------------------------------------------------------
    task automatic put_bus_phase(input logic rs, input logic en, input logic [7:0] bus,
                                 input int unsigned hold);
        phase_t ph;
        ph.rs   = rs;
        ph.rw   = 1'b0;
        ph.en   = en;
        ph.bus  = bus;
        ph.hold = (hold > 32'hFFFF) ? 16'hFFFF : hold[15:0];
        ph.last = 1'b0;
        scratch_phases[scratch_n] = ph;
        scratch_n++;
    endtask

    // setup, strobe and release of one byte
    task automatic put_byte_write(input logic rs, input logic [7:0] bus,
                                  input int unsigned extra);
        put_bus_phase(rs, 1'b0, bus, 0);
        put_bus_phase(rs, 1'b1, bus, 32'(pulse_cfg));
        put_bus_phase(rs, 1'b0, bus, 32'(settle_cfg) + extra);
    endtask

    task automatic expand_request(input lcdws_pkg::kind_t k, input logic [7:0] v,
                                  input logic s, output int n);
        phase_t ph;
        scratch_n = 0;
        case (k)
            lcdws_pkg::KIND_INIT:
            begin
                put_bus_phase(1'b0, 1'b0, 8'h00, 32'(power_cfg));
                put_byte_write(1'b0, lcdws_pkg::CMD_FUNC_SET, 32'(settle_cfg));
                put_byte_write(1'b0, lcdws_pkg::CMD_ENTRY, 32'(settle_cfg));
                put_byte_write(1'b0, lcdws_pkg::CMD_DISP_ON, 32'(settle_cfg));
                put_byte_write(1'b0, lcdws_pkg::CMD_CLEAR, 32'(clear_cfg));
            end
            lcdws_pkg::KIND_CMD:
            begin
                put_byte_write(1'b0, v, 0);
            end
            lcdws_pkg::KIND_CHAR:
            begin
                if (s)
                    char_pos = '0;
                // second-line jump once the counter reaches the line length
                if (char_pos == line_len_cfg && char_pos < lcdws_pkg::POS_MAX)
                    put_byte_write(1'b0, lcdws_pkg::CMD_LINE_TWO, 0);
                put_byte_write(1'b1, v, 0);
                if (char_pos < lcdws_pkg::POS_MAX)
                    char_pos++;
            end
            default:
            begin
                put_byte_write(1'b0, lcdws_pkg::CMD_CLEAR, 32'(clear_cfg));
            end
        endcase
        for (int i = 0; i < scratch_n; i++)
        begin
            ph = scratch_phases[i];
            ph.last = (i == scratch_n - 1);
            pending_phases.push_back(ph);
        end
        n = scratch_n;
    endtask

    // ------------------------------------------------------------------
    // scoreboard: check popped phases, predict pushed requests
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        phase_t want;
        int     n;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_phases.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: phase with nothing pending, expected none, actual bus %0h hold %0h",
                             $time, bus_byte, hold_us);
                end
                else
                begin
                    want = pending_phases.pop_front();
                    check_field("reg_select", 32'(want.rs), 32'(reg_select));
                    check_field("read_write", 32'(want.rw), 32'(read_write));
                    check_field("enable", 32'(want.en), 32'(enable));
                    check_field("bus_byte", 32'(want.bus), 32'(bus_byte));
                    check_field("hold_us", 32'(want.hold), 32'(hold_us));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (push && !full)
            begin
                expand_request(req_kind, req_value, req_start, n);
                if (row_typed)
                begin
                    check_field("phase count", 32'(row_n), 32'(n));
                    check_field("final bus_byte", 32'(row_bus),
                                32'(scratch_phases[n-1].bus));
                    check_field("final hold_us", 32'(row_hold),
                                32'(scratch_phases[n-1].hold));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // phase consumer with random stalls
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int r;
        rx_cycles++;
        if (rx_cycles % 300 == 0)
            rx_idle_on = ($urandom_range(0, 2) != 0);
        if (rx_stall > 0)
        begin
            pop <= 1'b0;
            rx_stall--;
        end
        else
        begin
            pop <= 1'b1;
            if (rx_idle_on)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    rx_stall = $urandom_range(1, 3);
                else if (r < 23)
                    rx_stall = $urandom_range(15, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    task automatic send_request(input lcdws_pkg::kind_t k, input logic [7:0] v,
                                input logic s, input logic typed, input logic [3:0] tn,
                                input logic [7:0] tbus, input logic [15:0] thold);
        int gap;
        int r;
        @(negedge clk);
        push      <= 1'b1;
        req_kind  <= k;
        req_value <= v;
        req_start <= s;
        row_typed <= typed;
        row_n     <= tn;
        row_bus   <= tbus;
        row_hold  <= thold;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        gap = 0;
        if (tx_idle_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(10, 40);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop pushing and wait for every pending phase
    task automatic drain_all();
        @(negedge clk);
        push <= 1'b0;
        while (pending_phases.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write followed by a read-back of the same register
    task automatic reg_access(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] stored;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            lcdws_pkg::REG_LINE_LENGTH: line_len_cfg = data[5:0];
            lcdws_pkg::REG_PULSE_US:    pulse_cfg    = data[7:0];
            lcdws_pkg::REG_SETTLE_US:   settle_cfg   = data[9:0];
            lcdws_pkg::REG_CLEAR_US:    clear_cfg    = data[15:0];
            lcdws_pkg::REG_POWER_UP_US: power_cfg    = data[15:0];
            default: ;
        endcase
        // read setup follows straight on
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx <= lcdws_pkg::REG_POWER_UP_US)
        begin
            case (idx)
                lcdws_pkg::REG_LINE_LENGTH: stored = {26'd0, line_len_cfg};
                lcdws_pkg::REG_PULSE_US:    stored = {24'd0, pulse_cfg};
                lcdws_pkg::REG_SETTLE_US:   stored = {22'd0, settle_cfg};
                lcdws_pkg::REG_CLEAR_US:    stored = {16'd0, clear_cfg};
                default:                    stored = {16'd0, power_cfg};
            endcase
            check_field("prdata", stored, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random traffic, mostly strings of characters
    task automatic run_batch(input int budget);
        int r;
        int len;
        int hi;
        int c;
        while (budget > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                hi = 2 * line_len_cfg + 3;
                if (hi > 70)
                    hi = 70;
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, hi);
                else if (r < 88)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(60, 70);   // may run the counter into saturation
                for (c = 0; c < len; c++)
                    send_request(lcdws_pkg::KIND_CHAR, 8'($urandom_range(0, 255)),
                                 (c == 0) ? 1'b1 : ($urandom_range(0, 19) == 0),
                                 1'b0, 4'd0, 8'h00, 16'h0000);
                budget -= len;
            end
            else if (r < 96)
            begin
                if (r < 70)
                    send_request(lcdws_pkg::KIND_CMD, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0, 4'd0, 8'h00, 16'h0000);
                else if (r < 80)
                    send_request(lcdws_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0, 4'd0, 8'h00, 16'h0000);
                else if (r < 85)
                    send_request(lcdws_pkg::KIND_INIT, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0, 4'd0, 8'h00, 16'h0000);
                else
                    send_request(lcdws_pkg::KIND_CHAR, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0, 4'd0, 8'h00, 16'h0000);
                budget--;
            end
            else
            begin
                // hold off until the bus side has caught up
                drain_all();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run timeout
    // ------------------------------------------------------------------
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t    row;
        logic [2:0]  idx;
        logic [31:0] data;
        int          w;
        int          r;

        // is_reg, index, data, kind, value, start, typed, count, final bus, final hold
        dir_rows = '{
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_INIT,  8'h00, 1'b0, 1'b1,
              4'd13, 8'h01, 16'd2040},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CMD,   8'h00, 1'b0, 1'b1,
              4'd3,  8'h00, 16'd40},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CMD,   8'hFF, 1'b1, 1'b1,
              4'd3,  8'hFF, 16'd40},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CLEAR, 8'hFF, 1'b1, 1'b1,
              4'd3,  8'h01, 16'd2040},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h00, 1'b1, 1'b1,
              4'd3,  8'h00, 16'd40},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'hFF, 1'b0, 1'b0,
              4'd0,  8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_LINE_LENGTH, 32'd1, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h41, 1'b1, 1'b1,
              4'd3,  8'h41, 16'd40},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h42, 1'b0, 1'b1,
              4'd6,  8'h42, 16'd40},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h43, 1'b0, 1'b0,
              4'd0,  8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_LINE_LENGTH, 32'hFFFF_FFC0, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h44, 1'b1, 1'b1,
              4'd6,  8'h44, 16'd40},
            '{1'b1, REG_SPARE_FIRST, 32'hFFFF_FFFF, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_SETTLE_US, 32'd1023, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_CLEAR_US, 32'd65535, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b1,
              4'd3,  8'h01, 16'hFFFF},
            '{1'b1, lcdws_pkg::REG_PULSE_US, 32'd255, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_POWER_UP_US, 32'd65535, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_INIT,  8'hFF, 1'b1, 1'b1,
              4'd13, 8'h01, 16'hFFFF},
            '{1'b1, lcdws_pkg::REG_SETTLE_US, 32'd0, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_CLEAR_US, 32'd0, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b1, lcdws_pkg::REG_PULSE_US, 32'd0, lcdws_pkg::KIND_INIT, 8'h00,
              1'b0, 1'b0, 4'd0, 8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b1,
              4'd3,  8'h01, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CMD,   8'hA5, 1'b0, 1'b0,
              4'd0,  8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_INIT,  8'h00, 1'b0, 1'b0,
              4'd0,  8'h00, 16'd0},
            '{1'b0, 3'd0, 32'd0, lcdws_pkg::KIND_CHAR,  8'h3C, 1'b0, 1'b0,
              4'd0,  8'h00, 16'd0}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.is_reg)
            begin
                drain_all();
                reg_access(row.reg_idx, row.reg_data);
            end
            else
            begin
                send_request(row.kind, row.val, row.start, row.typed,
                             row.t_n, row.t_bus, row.t_hold);
            end
        end

        // random part, new register settings between batches
        while (items_sent < ITEM_TARGET)
        begin
            drain_all();
            for (int k = 0; k <= lcdws_pkg::REG_POWER_UP_US; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    idx = 3'(k);
                    r = $urandom_range(0, 99);
                    case (idx)
                        lcdws_pkg::REG_LINE_LENGTH:
                        begin
                            w = 6;
                            if (r < 35)      data = $urandom_range(1, 8);
                            else if (r < 55) data = $urandom_range(1, 40);
                            else if (r < 65) data = 1;
                            else if (r < 75) data = 40;
                            else if (r < 85) data = 63;
                            else if (r < 90) data = 0;
                            else             data = $urandom_range(0, 63);
                        end
                        lcdws_pkg::REG_PULSE_US:
                        begin
                            w = 8;
                            if (r < 15)      data = 1;
                            else if (r < 30) data = 255;
                            else if (r < 35) data = 0;
                            else             data = $urandom_range(1, 255);
                        end
                        lcdws_pkg::REG_SETTLE_US:
                        begin
                            w = 10;
                            if (r < 15)      data = 1;
                            else if (r < 30) data = 1023;
                            else if (r < 35) data = 0;
                            else             data = $urandom_range(1, 1023);
                        end
                        default:
                        begin
                            w = 16;
                            if (r < 15)      data = 1;
                            else if (r < 30) data = 65535;
                            else if (r < 35) data = 0;
                            else             data = $urandom_range(1, 65535);
                        end
                    endcase
                    // junk above the register width must be dropped
                    if ($urandom_range(0, 3) == 0)
                        data = data | ($urandom() << w);
                    reg_access(idx, data);
                end
            end
            if ($urandom_range(0, 4) == 0)
                reg_access(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
            tx_idle_on = ($urandom_range(0, 3) != 0);
            run_batch($urandom_range(25, 60));
        end

        drain_all();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
